// ===== rtl/mpp_pkg.sv =====
// shared constants and types for the 8x4 matrix panel packer
// no dependencies; imported by the packer, its band ram and its checker
package mpp_pkg;

    localparam int MR          = 8;
    localparam int KR          = 4;
    localparam int ELEM_W      = 16;
    localparam int WORD_W      = KR * ELEM_W;
    localparam int MAX_COLS    = 4096;
    localparam int GROUPS_MAX  = (MAX_COLS + KR - 1) / KR;
    localparam int STORE_ROWS  = MR - 1;
    localparam int STORE_DEPTH = STORE_ROWS * GROUPS_MAX;
    localparam int COLS_W      = 13;
    localparam int ROWS_W      = 16;
    localparam int GRP_W       = $clog2(GROUPS_MAX);
    localparam int LANE_W      = $clog2(MR);
    localparam int ADDR_W      = LANE_W + GRP_W;
    localparam int CFG_W       = 16;

    localparam logic CFG_NUM_COLS = 1'b0;
    localparam logic CFG_NUM_ROWS = 1'b1;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [WORD_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_ram_req;

endpackage

// ===== rtl/matrix_panel_packer_8x4.sv =====
// channel   dir  handshake                       payload
// s_axis    in   i_s_axis_tvalid/o_s_axis_tready  tdata: elem_a..elem_d
// m_axis    out  o_m_axis_tvalid/i_m_axis_tready  tdata: out_a..out_d, tlast: run_last,
//                                                 tuser: lane_row, matrix_done
// cfg       in   i_cfg_we                         i_cfg_addr, i_cfg_wdata
//
// a group that is only stored is accepted, then masked and written to the band ram
// a group on a band's last row is accepted and masked, then each stored row takes a ram read
// and a send and each other row a send, one row after another behind the single read port
// a stalled output word holds the sequencer; only the panel's last word waits while
// the next group is accepted
// synchronous active-low reset clears counters and handshake state; no ram clearing
// depends on mpp_pkg and mpp_band_ram
module matrix_panel_packer_8x4 import mpp_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  logic [WORD_W-1:0] i_s_axis_tdata,   // elem_a, elem_b, elem_c, elem_d
    output logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    output logic [WORD_W-1:0] o_m_axis_tdata,   // out_a, out_b, out_c, out_d
    output logic              o_m_axis_tlast,
    output logic [3:0]        o_m_axis_tuser,   // lane_row[2:0], matrix_done
    input  logic              i_cfg_we,
    input  logic              i_cfg_addr,
    input  logic [CFG_W-1:0]  i_cfg_wdata
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_PREP = 2'd1;
    localparam logic [1:0] S_RD   = 2'd2;
    localparam logic [1:0] S_SEND = 2'd3;

    localparam logic [LANE_W-1:0] LAST_LANE = LANE_W'(MR - 1);
    localparam logic [LANE_W-1:0] STORE_TOP = LANE_W'(STORE_ROWS);

    logic [1:0]        r_state, n_state;
    logic [COLS_W-1:0] r_num_cols, n_num_cols;
    logic [ROWS_W-1:0] r_num_rows, n_num_rows;
    logic [WORD_W-1:0] r_in, n_in;
    logic [LANE_W-1:0] r_row_in_band, n_row_in_band;
    logic [GRP_W-1:0]  r_group, n_group;
    logic [ROWS_W-1:0] r_rows_seen, n_rows_seen;
    logic [WORD_W-1:0] r_word, n_word;
    logic [GRP_W-1:0]  r_g, n_g;
    logic [LANE_W-1:0] r_emit_rib, n_emit_rib;
    logic              r_last_all, n_last_all;
    logic [LANE_W-1:0] r_cnt, n_cnt;
    logic [WORD_W-1:0] r_first, n_first;
    logic              r_out_valid, n_out_valid;
    logic [WORD_W-1:0] r_out_data, n_out_data;
    logic [LANE_W-1:0] r_out_lane, n_out_lane;
    logic              r_out_done, n_out_done;

    logic [COLS_W-1:0] cols_eff;
    logic [COLS_W-1:0] cols_plus;
    logic [GRP_W:0]    groups;
    logic [GRP_W-1:0]  g_cl;
    logic              last_group;
    logic              last_row;
    logic              emit;
    logic [WORD_W-1:0] word_masked;
    logic [ROWS_W-1:0] rows_eff;
    logic              out_free;
    logic [WORD_W-1:0] send_word;
    logic [WORD_W-1:0] rd_data;
    t_ram_req          ram_req;

    mpp_band_ram u_ram (
        .i_clk     (i_clk),
        .i_req     (ram_req),
        .o_rd_data (rd_data)
    );

    // effective counts and masking for the held group
    always_comb begin
        if (r_num_cols == '0) begin
            cols_eff = COLS_W'(1);
        end else if (r_num_cols > COLS_W'(MAX_COLS)) begin
            cols_eff = COLS_W'(MAX_COLS);
        end else begin
            cols_eff = r_num_cols;
        end
        rows_eff   = (r_num_rows == '0) ? ROWS_W'(1) : r_num_rows;
        cols_plus  = cols_eff + COLS_W'(KR - 1);
        groups     = cols_plus[COLS_W-1:2];
        if ({1'b0, r_group} >= groups) begin
            g_cl = GRP_W'(groups - (GRP_W+1)'(1));
        end else begin
            g_cl = r_group;
        end
        last_group = (({1'b0, g_cl} + (GRP_W+1)'(1)) >= groups);
        last_row   = (({1'b0, r_rows_seen} + (ROWS_W+1)'(1)) >= {1'b0, rows_eff});
        emit       = (r_row_in_band >= STORE_TOP) || last_row;
        for (int i = 0; i < KR; i++) begin
            if ((COLS_W'({g_cl, 2'b00}) + COLS_W'(i)) < cols_eff) begin
                word_masked[i*ELEM_W +: ELEM_W] = r_in[i*ELEM_W +: ELEM_W];
            end else begin
                word_masked[i*ELEM_W +: ELEM_W] = '0;
            end
        end
    end

    assign out_free = !r_out_valid || i_m_axis_tready;

    always_comb begin
        if (r_cnt < r_emit_rib) begin
            send_word = rd_data;
        end else if (r_cnt == r_emit_rib) begin
            send_word = r_word;
        end else begin
            send_word = r_first;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_num_cols    = r_num_cols;
        n_num_rows    = r_num_rows;
        n_in          = r_in;
        n_row_in_band = r_row_in_band;
        n_group       = r_group;
        n_rows_seen   = r_rows_seen;
        n_word        = r_word;
        n_g           = r_g;
        n_emit_rib    = r_emit_rib;
        n_last_all    = r_last_all;
        n_cnt         = r_cnt;
        n_first       = r_first;
        n_out_valid   = r_out_valid && !i_m_axis_tready;
        n_out_data    = r_out_data;
        n_out_lane    = r_out_lane;
        n_out_done    = r_out_done;
        ram_req       = '0;

        if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_NUM_COLS: n_num_cols = i_cfg_wdata[COLS_W-1:0];
                CFG_NUM_ROWS: n_num_rows = i_cfg_wdata[ROWS_W-1:0];
                default:      n_num_cols = r_num_cols;
            endcase
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_in    = i_s_axis_tdata;
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                n_word     = word_masked;
                n_g        = g_cl;
                n_emit_rib = r_row_in_band;
                n_last_all = last_row && last_group;
                n_cnt      = '0;
                if (emit) begin
                    n_state = (r_row_in_band != '0) ? S_RD : S_SEND;
                end else begin
                    ram_req.we    = 1'b1;
                    ram_req.waddr = {r_row_in_band, g_cl};
                    ram_req.wdata = word_masked;
                    n_state       = S_IDLE;
                end
                if (!last_group) begin
                    n_group = g_cl + GRP_W'(1);
                end else begin
                    n_group = '0;
                    if (last_row) begin
                        n_rows_seen   = '0;
                        n_row_in_band = '0;
                    end else begin
                        n_rows_seen   = r_rows_seen + ROWS_W'(1);
                        n_row_in_band = (r_row_in_band >= STORE_TOP) ? '0
                                                                     : r_row_in_band + LANE_W'(1);
                    end
                end
            end
            S_RD: begin
                ram_req.re    = 1'b1;
                ram_req.raddr = {r_cnt, r_g};
                n_state       = S_SEND;
            end
            S_SEND: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = send_word;
                    n_out_lane  = r_cnt;
                    n_out_done  = (r_cnt == LAST_LANE) && r_last_all;
                    // row 0 of the band is what missing rows repeat
                    if (r_cnt == '0) begin
                        n_first = send_word;
                    end
                    if (r_cnt == LAST_LANE) begin
                        n_state = S_IDLE;
                    end else begin
                        n_cnt   = r_cnt + LANE_W'(1);
                        n_state = (({1'b0, r_cnt} + (LANE_W+1)'(1)) < {1'b0, r_emit_rib})
                                  ? S_RD : S_SEND;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_num_cols    <= COLS_W'(1);
            r_num_rows    <= ROWS_W'(1);
            r_row_in_band <= '0;
            r_group       <= '0;
            r_rows_seen   <= '0;
            r_cnt         <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_num_cols    <= n_num_cols;
            r_num_rows    <= n_num_rows;
            r_row_in_band <= n_row_in_band;
            r_group       <= n_group;
            r_rows_seen   <= n_rows_seen;
            r_cnt         <= n_cnt;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in       <= n_in;
        r_word     <= n_word;
        r_g        <= n_g;
        r_emit_rib <= n_emit_rib;
        r_last_all <= n_last_all;
        r_first    <= n_first;
        r_out_data <= n_out_data;
        r_out_lane <= n_out_lane;
        r_out_done <= n_out_done;
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tlast  = (r_out_lane == LAST_LANE);
    assign o_m_axis_tuser  = {r_out_done, r_out_lane};

endmodule

// ===== rtl/mpp_band_ram.sv =====
// band store: one write port and one registered read port
// depends on mpp_pkg for depth, widths and the request struct
module mpp_band_ram import mpp_pkg::*; (
    input  logic              i_clk,
    input  t_ram_req          i_req,
    output logic [WORD_W-1:0] o_rd_data
);

    logic [WORD_W-1:0] mem [0:STORE_DEPTH-1];
    logic [WORD_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rd_data <= mem[i_req.raddr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/mpp_checker.sv =====
// port-level checks for the panel packer, bound to the top level
// depends on mpp_pkg and matrix_panel_packer_8x4
module mpp_checker import mpp_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_s_axis_tvalid,
    input logic              o_s_axis_tready,
    input logic              o_m_axis_tvalid,
    input logic              i_m_axis_tready,
    input logic [WORD_W-1:0] o_m_axis_tdata,
    input logic              o_m_axis_tlast,
    input logic [3:0]        o_m_axis_tuser
);

    // tlast marks the panel's bottom lane
    a_last_lane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tlast == (o_m_axis_tuser[2:0] == 3'(MR - 1))))
        else $error("tlast does not match lane");

    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[3]) |-> o_m_axis_tlast)
        else $error("matrix done off the last lane");

    // every accepted word is followed by a preparation state in which ready is low
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("ready right after accept");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
        (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)))
        else $error("stalled word changed");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

endmodule

bind matrix_panel_packer_8x4 mpp_checker u_mpp_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast),
    .o_m_axis_tuser  (o_m_axis_tuser)
);
